// ===== hdl/tst_pkg.sv =====
// ============================================================================
// tst_pkg - touch slot tracker shared definitions
// Event and action codes, register indexes, controller/datapath interface
// types and the position scaling function.
// ============================================================================
package tst_pkg;

    localparam int POS_W        = 16;
    localparam int PTR_W        = 4;
    localparam int ACT_W        = 3;
    localparam int EV_W         = 3;
    localparam int SLOT_OUT_W   = 3;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 16;
    localparam int MAX_POINTERS = 16;

    localparam logic [CFG_IDX_W-1:0] REG_INVERSE_SCALE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_THRESHOLD = 8'd1;

    localparam logic [CFG_DATA_W-1:0] INVERSE_SCALE_RST = 16'd4096;
    localparam logic [CFG_DATA_W-1:0] MOVE_THRESHOLD_RST = 16'd0;

    localparam logic [ACT_W-1:0] ACT_DOWN       = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PTR_DOWN   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_MOVE       = 3'd2;
    localparam logic [ACT_W-1:0] ACT_PTR_UP     = 3'd3;
    localparam logic [ACT_W-1:0] ACT_UP         = 3'd4;

    localparam logic KIND_RESET = 1'b1;

    localparam logic [EV_W-1:0] EV_ON     = 3'd0;
    localparam logic [EV_W-1:0] EV_DRAG   = 3'd1;
    localparam logic [EV_W-1:0] EV_MOVE   = 3'd2;
    localparam logic [EV_W-1:0] EV_OFF    = 3'd3;
    localparam logic [EV_W-1:0] EV_CANCEL = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_MUL_Y,
        ST_SQ_X,
        ST_SQ_Y,
        ST_COMMIT,
        ST_CANCEL
    } state_t;

    typedef enum logic [1:0] {
        MUL_X,
        MUL_Y,
        MUL_DX,
        MUL_DY
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     lookup;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     sat_x;
        logic     sat_y;
        logic     save_sq;
        logic     commit;
        logic     cancel_step;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic cur_down;
        logic idx_last;
    } status_t;

    // (p + 2048) >> 12, rounded to nearest and saturated to the position range
    function automatic logic [POS_W-1:0] round_sat(input logic [31:0] p);
        logic [32:0] r;
        r = {1'b0, p} + 33'd2048;
        if (r[32:12] > 21'd65535) begin
            return 16'hFFFF;
        end else begin
            return r[27:12];
        end
    endfunction

endpackage

// ===== hdl/touch_slot_tracker.sv =====
// ============================================================================
// touch_slot_tracker - multi-touch pointer slot tracker
// Maps pointer indices of motion events to a table of slots and emits on,
// drag, move, off and cancel events with scaled positions.
// ============================================================================
// One input transaction is processed at a time. A pointer record is taken
// in the idle state and its result is registered at the commit: the single
// shared 16x16 multiplier is used four times in turn (x scale, y scale, dx
// squared, dy squared) before the commit state. A reset visits one slot per
// cycle, unless back-pressure holds it, and emits its cancels in slot order.
// Back-pressure on the result channel adds stall cycles at the commit or at
// each cancel. Configuration writes are always ready and take effect in the
// next cycle.
module touch_slot_tracker #(
    parameter int NUM_SLOTS = 5
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_kind,
    input  logic [tst_pkg::ACT_W-1:0]           s_action,
    input  logic [tst_pkg::PTR_W-1:0]           s_action_pointer,
    input  logic [tst_pkg::PTR_W-1:0]           s_pointer_index,
    input  logic [tst_pkg::POS_W-1:0]           s_pos_x,
    input  logic [tst_pkg::POS_W-1:0]           s_pos_y,
    input  logic                                s_last_pointer,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [tst_pkg::EV_W-1:0]            m_event_kind,
    output logic [tst_pkg::SLOT_OUT_W-1:0]      m_slot,
    output logic [tst_pkg::POS_W-1:0]           m_old_x,
    output logic [tst_pkg::POS_W-1:0]           m_old_y,
    output logic [tst_pkg::POS_W-1:0]           m_new_x,
    output logic [tst_pkg::POS_W-1:0]           m_new_y,
    output logic                                m_last_result,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tst_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tst_pkg::CFG_DATA_W-1:0]      cfg_data
);

    tst_pkg::cmd_t    cmd;
    tst_pkg::status_t status;

    assign cfg_ready = 1'b1;

    tst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_kind),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tst_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_action         (s_action),
        .s_action_pointer (s_action_pointer),
        .s_pointer_index  (s_pointer_index),
        .s_pos_x          (s_pos_x),
        .s_pos_y          (s_pos_y),
        .s_last_pointer   (s_last_pointer),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_kind     (m_event_kind),
        .m_slot           (m_slot),
        .m_old_x          (m_old_x),
        .m_old_y          (m_old_y),
        .m_new_x          (m_new_x),
        .m_new_y          (m_new_y),
        .m_last_result    (m_last_result),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

endmodule

// ===== hdl/tst_ctrl.sv =====
// ============================================================================
// tst_ctrl - touch slot tracker controller
// Sequences one input transaction at a time through the shared datapath:
// lookup, scaling, distance and commit for pointer records, a slot sweep
// for resets.
// ============================================================================
module tst_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_kind,
    output logic              s_ready,
    input  tst_pkg::status_t  status,
    output tst_pkg::cmd_t     cmd
);

    tst_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tst_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.mul_sel     = tst_pkg::MUL_X;
        s_ready         = 1'b0;
        unique case (state_reg)
            tst_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = (s_kind == tst_pkg::KIND_RESET) ? tst_pkg::ST_CANCEL
                                                                 : tst_pkg::ST_LOOKUP;
                end
            end
            tst_pkg::ST_LOOKUP: begin
                cmd.lookup  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = tst_pkg::MUL_X;
                state_next  = tst_pkg::ST_MUL_Y;
            end
            tst_pkg::ST_MUL_Y: begin
                cmd.sat_x   = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = tst_pkg::MUL_Y;
                state_next  = tst_pkg::ST_SQ_X;
            end
            tst_pkg::ST_SQ_X: begin
                cmd.sat_y   = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = tst_pkg::MUL_DX;
                state_next  = tst_pkg::ST_SQ_Y;
            end
            tst_pkg::ST_SQ_Y: begin
                cmd.save_sq = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = tst_pkg::MUL_DY;
                state_next  = tst_pkg::ST_COMMIT;
            end
            tst_pkg::ST_COMMIT: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = tst_pkg::ST_IDLE;
                end
            end
            tst_pkg::ST_CANCEL: begin
                if (status.out_free || !status.cur_down) begin
                    cmd.cancel_step = 1'b1;
                    if (status.idx_last) begin
                        state_next = tst_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = tst_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/tst_datapath.sv =====
// ============================================================================
// tst_datapath - touch slot tracker datapath
// Slot table, configuration registers, shared 16x16 multiplier, event
// decision and the output register.
// ============================================================================
module tst_datapath #(
    parameter int NUM_SLOTS = 5
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  tst_pkg::cmd_t                       cmd,
    output tst_pkg::status_t                    status,

    input  logic [tst_pkg::ACT_W-1:0]           s_action,
    input  logic [tst_pkg::PTR_W-1:0]           s_action_pointer,
    input  logic [tst_pkg::PTR_W-1:0]           s_pointer_index,
    input  logic [tst_pkg::POS_W-1:0]           s_pos_x,
    input  logic [tst_pkg::POS_W-1:0]           s_pos_y,
    input  logic                                s_last_pointer,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [tst_pkg::EV_W-1:0]            m_event_kind,
    output logic [tst_pkg::SLOT_OUT_W-1:0]      m_slot,
    output logic [tst_pkg::POS_W-1:0]           m_old_x,
    output logic [tst_pkg::POS_W-1:0]           m_old_y,
    output logic [tst_pkg::POS_W-1:0]           m_new_x,
    output logic [tst_pkg::POS_W-1:0]           m_new_y,
    output logic                                m_last_result,

    input  logic                                cfg_valid,
    input  logic [tst_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tst_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

    logic [tst_pkg::CFG_DATA_W-1:0] inv_scale_reg;
    logic [tst_pkg::CFG_DATA_W-1:0] thresh_reg;

    logic [tst_pkg::ACT_W-1:0] action_reg;
    logic [tst_pkg::PTR_W-1:0] aptr_reg;
    logic [tst_pkg::PTR_W-1:0] ptr_reg;
    logic [tst_pkg::POS_W-1:0] px_reg;
    logic [tst_pkg::POS_W-1:0] py_reg;
    logic                      last_reg;

    logic                      slot_used_reg  [NUM_SLOTS];
    logic [tst_pkg::PTR_W-1:0] slot_owner_reg [NUM_SLOTS];
    logic                      slot_down_reg  [NUM_SLOTS];
    logic [tst_pkg::POS_W-1:0] slot_x_reg     [NUM_SLOTS];
    logic [tst_pkg::POS_W-1:0] slot_y_reg     [NUM_SLOTS];

    logic [SLOT_W-1:0] idx_reg;
    logic              slot_ok_reg;
    logic              alloc_reg;
    logic [31:0]       mul_reg;
    logic [31:0]       d2x_reg;
    logic [tst_pkg::POS_W-1:0] nx_reg;
    logic [tst_pkg::POS_W-1:0] ny_reg;

    logic                       out_valid_reg;
    logic [tst_pkg::EV_W-1:0]   out_ev_reg;
    logic [SLOT_W-1:0]          out_slot_reg;
    logic [tst_pkg::POS_W-1:0]  out_ox_reg;
    logic [tst_pkg::POS_W-1:0]  out_oy_reg;
    logic [tst_pkg::POS_W-1:0]  out_nx_reg;
    logic [tst_pkg::POS_W-1:0]  out_ny_reg;
    logic                       out_last_reg;

    logic              found, any_free;
    logic [SLOT_W-1:0] find_idx, free_idx;
    logic              eligible;
    logic [tst_pkg::POS_W-1:0] ox, oy, abs_dx, abs_dy, mul_a, mul_b;
    logic [31:0]       mul_prod;
    logic [32:0]       d2;
    logic              was, on_w, moved, emit, down_above, out_free, do_release;
    logic [tst_pkg::EV_W-1:0] ev;

    // slot lookup
    always_comb begin
        found    = 1'b0;
        any_free = 1'b0;
        find_idx = '0;
        free_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (slot_used_reg[i] && slot_owner_reg[i] == ptr_reg) begin
                found    = 1'b1;
                find_idx = SLOT_W'(i);
            end
            if (!slot_used_reg[i]) begin
                any_free = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    assign eligible = (action_reg <= tst_pkg::ACT_UP) &&
                      ({28'd0, ptr_reg} < 32'(tst_pkg::MAX_POINTERS));

    assign ox     = slot_x_reg[idx_reg];
    assign oy     = slot_y_reg[idx_reg];
    assign abs_dx = (nx_reg >= ox) ? (nx_reg - ox) : (ox - nx_reg);
    assign abs_dy = (ny_reg >= oy) ? (ny_reg - oy) : (oy - ny_reg);

    always_comb begin
        unique case (cmd.mul_sel)
            tst_pkg::MUL_X:  begin mul_a = px_reg; mul_b = inv_scale_reg; end
            tst_pkg::MUL_Y:  begin mul_a = py_reg; mul_b = inv_scale_reg; end
            tst_pkg::MUL_DX: begin mul_a = abs_dx; mul_b = abs_dx;        end
            tst_pkg::MUL_DY: begin mul_a = abs_dy; mul_b = abs_dy;        end
            default:         begin mul_a = px_reg; mul_b = inv_scale_reg; end
        endcase
    end

    assign mul_prod = {16'd0, mul_a} * {16'd0, mul_b};

    // event decision
    assign d2    = {1'b0, d2x_reg} + {1'b0, mul_reg};
    assign was   = slot_down_reg[idx_reg];
    assign on_w  = !((action_reg == tst_pkg::ACT_PTR_UP || action_reg == tst_pkg::ACT_UP) &&
                     ptr_reg == aptr_reg);
    assign moved = (was == on_w) && (d2 > {17'd0, thresh_reg});

    always_comb begin
        emit = 1'b1;
        priority if (!was && on_w) begin
            ev = tst_pkg::EV_ON;
        end else if (moved) begin
            ev = on_w ? tst_pkg::EV_DRAG : tst_pkg::EV_MOVE;
        end else if (was && !on_w) begin
            ev = tst_pkg::EV_OFF;
        end else begin
            ev   = tst_pkg::EV_ON;
            emit = 1'b0;
        end
    end

    assign do_release = last_reg &&
                        (action_reg == tst_pkg::ACT_PTR_UP || action_reg == tst_pkg::ACT_UP);

    always_comb begin
        down_above = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (SLOT_W'(i) > idx_reg && slot_down_reg[i]) begin
                down_above = 1'b1;
            end
        end
    end

    assign out_free        = !out_valid_reg || m_ready;
    assign status.out_free = out_free;
    assign status.cur_down = slot_down_reg[idx_reg];
    assign status.idx_last = (idx_reg == LAST_IDX);

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_scale_reg <= tst_pkg::INVERSE_SCALE_RST;
            thresh_reg    <= tst_pkg::MOVE_THRESHOLD_RST;
        end else if (cfg_valid) begin
            if (cfg_index == tst_pkg::REG_INVERSE_SCALE) begin
                inv_scale_reg <= cfg_data;
            end else if (cfg_index == tst_pkg::REG_MOVE_THRESHOLD) begin
                thresh_reg <= cfg_data;
            end
        end
    end

    // transaction payload and arithmetic
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            action_reg <= s_action;
            aptr_reg   <= s_action_pointer;
            ptr_reg    <= s_pointer_index;
            px_reg     <= s_pos_x;
            py_reg     <= s_pos_y;
            last_reg   <= s_last_pointer;
        end
        if (cmd.mul_en) begin
            mul_reg <= mul_prod;
        end
        if (cmd.sat_x) begin
            nx_reg <= tst_pkg::round_sat(mul_reg);
        end
        if (cmd.sat_y) begin
            ny_reg <= tst_pkg::round_sat(mul_reg);
        end
        if (cmd.save_sq) begin
            d2x_reg <= mul_reg;
        end
        if (cmd.lookup) begin
            alloc_reg <= eligible && !found && (action_reg <= tst_pkg::ACT_PTR_DOWN) && any_free;
        end
    end

    // slot table and control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            slot_ok_reg <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                slot_used_reg[i]  <= 1'b0;
                slot_owner_reg[i] <= '0;
                slot_down_reg[i]  <= 1'b0;
                slot_x_reg[i]     <= '0;
                slot_y_reg[i]     <= '0;
            end
        end else begin
            if (cmd.load) begin
                idx_reg <= '0;
            end
            if (cmd.lookup) begin
                idx_reg     <= found ? find_idx : free_idx;
                slot_ok_reg <= eligible &&
                               (found || ((action_reg <= tst_pkg::ACT_PTR_DOWN) && any_free));
            end
            if (cmd.commit) begin
                if (slot_ok_reg) begin
                    slot_down_reg[idx_reg] <= on_w;
                    slot_x_reg[idx_reg]    <= nx_reg;
                    slot_y_reg[idx_reg]    <= ny_reg;
                    if (alloc_reg) begin
                        slot_used_reg[idx_reg]  <= 1'b1;
                        slot_owner_reg[idx_reg] <= ptr_reg;
                    end
                end
                if (do_release) begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (slot_used_reg[i]) begin
                            if (slot_owner_reg[i] == aptr_reg) begin
                                slot_used_reg[i]  <= 1'b0;
                                slot_owner_reg[i] <= '0;
                            end else if (slot_owner_reg[i] > aptr_reg) begin
                                slot_owner_reg[i] <= slot_owner_reg[i] - 1'b1;
                            end
                        end
                    end
                end
            end
            if (cmd.cancel_step) begin
                slot_down_reg[idx_reg] <= 1'b0;
                if (idx_reg != LAST_IDX) begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit && slot_ok_reg && emit) begin
            out_valid_reg <= 1'b1;
        end else if (cmd.cancel_step && slot_down_reg[idx_reg]) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && slot_ok_reg && emit) begin
            out_ev_reg   <= ev;
            out_slot_reg <= idx_reg;
            out_ox_reg   <= ox;
            out_oy_reg   <= oy;
            out_nx_reg   <= nx_reg;
            out_ny_reg   <= ny_reg;
            out_last_reg <= 1'b1;
        end else if (cmd.cancel_step && slot_down_reg[idx_reg]) begin
            out_ev_reg   <= tst_pkg::EV_CANCEL;
            out_slot_reg <= idx_reg;
            out_ox_reg   <= ox;
            out_oy_reg   <= oy;
            out_nx_reg   <= ox;
            out_ny_reg   <= oy;
            out_last_reg <= !down_above;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_event_kind  = out_ev_reg;
    assign m_slot        = tst_pkg::SLOT_OUT_W'(out_slot_reg);
    assign m_old_x       = out_ox_reg;
    assign m_old_y       = out_oy_reg;
    assign m_new_x       = out_nx_reg;
    assign m_new_y       = out_ny_reg;
    assign m_last_result = out_last_reg;

endmodule

// ===== verif/touch_slot_tracker_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// touch_slot_tracker_test - self-checking bench for the touch slot tracker
// Feeds multi-touch pointer records, slot resets and register writes through
// valid/ready channels with random idle bursts and back-pressure. A local
// slot-table model predicts every on/drag/move/off/cancel event, and each
// result transaction is compared field by field against the oldest
// prediction.
// ============================================================================
module touch_slot_tracker_test;

    import tst_pkg::*;

    localparam int NUM_SLOTS        = 5;
    localparam int RANDOM_RECORDS   = 144;
    localparam int RANDOM_PHASES    = 4;
    localparam int SETTLE_CYCLES    = 16;
    localparam int TAIL_ITEMS       = 30;
    localparam int HOLD_AFTER       = 80;
    localparam int LONG_HOLD_CYCLES = 150;
    localparam int CYCLE_LIMIT      = 200000;

    localparam logic              KIND_POINTER = 1'b0;
    localparam logic [ACT_W-1:0]  ACT_OTHER    = 3'd5;
    localparam logic [ACT_W-1:0]  ACT_RESERVED = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 8'd255;

    typedef struct {
        logic              kind;
        logic [ACT_W-1:0]  action;
        logic [PTR_W-1:0]  aptr;
        logic [PTR_W-1:0]  ptr;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic              last;
    } touch_rec_t;

    typedef struct {
        logic [EV_W-1:0]       ev_kind;
        logic [SLOT_OUT_W-1:0] slot;
        logic [POS_W-1:0]      old_x;
        logic [POS_W-1:0]      old_y;
        logic [POS_W-1:0]      new_x;
        logic [POS_W-1:0]      new_y;
        logic                  last;
    } touch_event_t;

    typedef enum {
        STIM_RECORD,
        STIM_REG_WRITE,
        STIM_SETTLE
    } stim_op_e;

    typedef struct {
        stim_op_e              op;
        touch_rec_t            rec;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
    } stim_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic                   s_kind = 1'b0;
    logic [ACT_W-1:0]       s_action = '0;
    logic [PTR_W-1:0]       s_action_pointer = '0;
    logic [PTR_W-1:0]       s_pointer_index = '0;
    logic [POS_W-1:0]       s_pos_x = '0;
    logic [POS_W-1:0]       s_pos_y = '0;
    logic                   s_last_pointer = 1'b0;

    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [EV_W-1:0]        m_event_kind;
    logic [SLOT_OUT_W-1:0]  m_slot;
    logic [POS_W-1:0]       m_old_x;
    logic [POS_W-1:0]       m_old_y;
    logic [POS_W-1:0]       m_new_x;
    logic [POS_W-1:0]       m_new_y;
    logic                   m_last_result;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    touch_slot_tracker #(
        .NUM_SLOTS(NUM_SLOTS)
    ) uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_action         (s_action),
        .s_action_pointer (s_action_pointer),
        .s_pointer_index  (s_pointer_index),
        .s_pos_x          (s_pos_x),
        .s_pos_y          (s_pos_y),
        .s_last_pointer   (s_last_pointer),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_kind     (m_event_kind),
        .m_slot           (m_slot),
        .m_old_x          (m_old_x),
        .m_old_y          (m_old_y),
        .m_new_x          (m_new_x),
        .m_new_y          (m_new_y),
        .m_last_result    (m_last_result),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // slot table and registers of the prediction
    logic                  slot_taken   [NUM_SLOTS] = '{default: 1'b0};
    logic [PTR_W-1:0]      slot_ptr     [NUM_SLOTS] = '{default: '0};
    logic                  slot_pressed [NUM_SLOTS] = '{default: 1'b0};
    logic [POS_W-1:0]      slot_pos_x   [NUM_SLOTS] = '{default: '0};
    logic [POS_W-1:0]      slot_pos_y   [NUM_SLOTS] = '{default: '0};
    logic [CFG_DATA_W-1:0] inv_scale_reg     = INVERSE_SCALE_RST;
    logic [CFG_DATA_W-1:0] motion_thresh_reg = MOVE_THRESHOLD_RST;

    touch_event_t expected_events[$];
    stim_t        pending_stimulus[$];

    int unsigned rec_issued   = 0;
    int unsigned rec_accepted = 0;
    int unsigned cfg_issued   = 0;
    int unsigned cfg_accepted = 0;
    int unsigned mismatches   = 0;
    int unsigned records_queued = 0;

    logic draining   = 1'b0;
    int   settle_left = 0;
    int   gap_left    = 0;
    logic quiet_tail  = 1'b0;

    int   stall_left     = 0;
    int   long_hold_left = 0;
    logic long_hold_done = 1'b0;

    // gesture generator state
    int          n_active = 0;
    logic [POS_W-1:0] gen_x [16] = '{default: '0};
    logic [POS_W-1:0] gen_y [16] = '{default: '0};

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic logic [POS_W-1:0] scale_position(logic [POS_W-1:0] raw);
        logic [63:0] p;
        p = (64'(raw) * 64'(inv_scale_reg) + 64'd2048) >> 12;
        return (p > 64'hFFFF) ? 16'hFFFF : p[POS_W-1:0];
    endfunction

    function automatic touch_event_t make_event(logic [EV_W-1:0] ev, int s,
            logic [POS_W-1:0] ox, logic [POS_W-1:0] oy,
            logic [POS_W-1:0] nx, logic [POS_W-1:0] ny);
        touch_event_t e;
        e.ev_kind = ev;
        e.slot    = SLOT_OUT_W'(s);
        e.old_x   = ox;
        e.old_y   = oy;
        e.new_x   = nx;
        e.new_y   = ny;
        e.last    = 1'b0;
        return e;
    endfunction

    task automatic track_pointer_record(input touch_rec_t rec);
        touch_event_t evs [NUM_SLOTS];
        int n;
        int s;
        logic on, was, moved;
        logic [POS_W-1:0] nx, ny, ox, oy;
        longint dx, dy;
        n = 0;
        if (rec.kind == KIND_RESET) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (slot_pressed[i]) begin
                    evs[n] = make_event(EV_CANCEL, i, slot_pos_x[i], slot_pos_y[i],
                                        slot_pos_x[i], slot_pos_y[i]);
                    n++;
                    slot_pressed[i] = 1'b0;
                end
            end
        end else begin
            s = -1;
            on = 1'b1;
            if (rec.action <= ACT_UP && int'(rec.ptr) < MAX_POINTERS) begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (s < 0 && slot_taken[i] && slot_ptr[i] == rec.ptr) s = i;
                end
                if (s < 0 && rec.action <= ACT_PTR_DOWN) begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (s < 0 && !slot_taken[i]) begin
                            s = i;
                            slot_taken[i] = 1'b1;
                            slot_ptr[i] = rec.ptr;
                        end
                    end
                end
                if (rec.action >= ACT_PTR_UP) on = (rec.ptr != rec.aptr);
            end
            if (s >= 0) begin
                nx = scale_position(rec.x);
                ny = scale_position(rec.y);
                ox = slot_pos_x[s];
                oy = slot_pos_y[s];
                was = slot_pressed[s];
                dx = longint'(nx) - longint'(ox);
                dy = longint'(ny) - longint'(oy);
                moved = (was == on) && (dx * dx + dy * dy > longint'(motion_thresh_reg));
                slot_pressed[s] = on;
                slot_pos_x[s] = nx;
                slot_pos_y[s] = ny;
                if (!was && on) begin
                    evs[n] = make_event(EV_ON, s, ox, oy, nx, ny);
                    n++;
                end else if (moved) begin
                    evs[n] = make_event(on ? EV_DRAG : EV_MOVE, s, ox, oy, nx, ny);
                    n++;
                end else if (was && !on) begin
                    evs[n] = make_event(EV_OFF, s, ox, oy, nx, ny);
                    n++;
                end
            end
            // lifted pointer frees its slot, higher pointer indices close the gap
            if (rec.last && (rec.action == ACT_PTR_UP || rec.action == ACT_UP)) begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (slot_taken[i]) begin
                        if (slot_ptr[i] == rec.aptr) begin
                            slot_taken[i] = 1'b0;
                            slot_ptr[i] = '0;
                        end else if (slot_ptr[i] > rec.aptr) begin
                            slot_ptr[i] = slot_ptr[i] - 1'b1;
                        end
                    end
                end
            end
        end
        for (int k = 0; k < n; k++) begin
            evs[k].last = (k == n - 1);
            expected_events.push_back(evs[k]);
        end
    endtask

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic push_record(input logic kind, input logic [ACT_W-1:0] action,
            input logic [PTR_W-1:0] aptr, input logic [PTR_W-1:0] ptr,
            input logic [POS_W-1:0] x, input logic [POS_W-1:0] y, input logic last);
        stim_t st;
        st.op = STIM_RECORD;
        st.rec.kind = kind;
        st.rec.action = action;
        st.rec.aptr = aptr;
        st.rec.ptr = ptr;
        st.rec.x = x;
        st.rec.y = y;
        st.rec.last = last;
        st.reg_index = '0;
        st.reg_value = '0;
        pending_stimulus.push_back(st);
        records_queued++;
    endtask

    task automatic push_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        stim_t st;
        st = '{op: STIM_REG_WRITE, rec: '{default: '0}, reg_index: idx, reg_value: value};
        pending_stimulus.push_back(st);
    endtask

    task automatic push_settle();
        stim_t st;
        st = '{op: STIM_SETTLE, rec: '{default: '0}, reg_index: '0, reg_value: '0};
        pending_stimulus.push_back(st);
    endtask

    function automatic logic [POS_W-1:0] nudge(logic [POS_W-1:0] p);
        if ($urandom_range(0, 7) == 0) return POS_W'($urandom);
        return p + POS_W'($urandom_range(0, 96)) - 16'd48;
    endfunction

    // one motion event (or a noise record / slot reset)
    task automatic add_gesture();
        int r, k, n;
        logic broken, lift;
        logic [ACT_W-1:0] act;
        r = $urandom_range(0, 99);
        lift = 1'b0;
        if (r < 10) begin
            push_record(KIND_POINTER, ACT_W'($urandom_range(0, 7)),
                        PTR_W'($urandom_range(0, 15)), PTR_W'($urandom_range(0, 15)),
                        POS_W'($urandom), POS_W'($urandom), 1'($urandom_range(0, 1)));
        end else if (r < 15) begin
            push_record(KIND_RESET, ACT_W'($urandom_range(0, 7)),
                        PTR_W'($urandom_range(0, 15)), PTR_W'($urandom_range(0, 15)),
                        POS_W'($urandom), POS_W'($urandom), 1'($urandom_range(0, 1)));
        end else begin
            if (n_active == 0) begin
                act = ACT_DOWN;
                k = 0;
                gen_x[0] = POS_W'($urandom);
                gen_y[0] = POS_W'($urandom);
                n_active = 1;
                n = 1;
            end else if (n_active < 6 && r < 35) begin
                act = ACT_PTR_DOWN;
                k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n_active) : n_active;
                for (int i = n_active; i > k; i--) begin
                    gen_x[i] = gen_x[i-1];
                    gen_y[i] = gen_y[i-1];
                end
                gen_x[k] = POS_W'($urandom);
                gen_y[k] = POS_W'($urandom);
                n_active++;
                n = n_active;
            end else if (r < 48) begin
                act = (n_active == 1) ? ACT_UP : ACT_PTR_UP;
                k = $urandom_range(0, n_active - 1);
                n = n_active;
                lift = 1'b1;
            end else begin
                act = ACT_MOVE;
                k = $urandom_range(0, 15);
                n = n_active;
            end
            broken = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < n; i++) begin
                if (act == ACT_MOVE) begin
                    gen_x[i] = nudge(gen_x[i]);
                    gen_y[i] = nudge(gen_y[i]);
                end
                push_record(KIND_POINTER, act, PTR_W'(k), PTR_W'(i), gen_x[i], gen_y[i],
                            (i == n - 1) && !broken);
            end
            if (lift) begin
                for (int i = k; i < n_active - 1; i++) begin
                    gen_x[i] = gen_x[i+1];
                    gen_y[i] = gen_y[i+1];
                end
                n_active--;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // driver: input and register channels, changes on the falling edge
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : driver
        stim_t st;
        logic  next_s, next_cfg;
        next_s = s_valid;
        next_cfg = cfg_valid;
        if (aresetn && rec_issued == rec_accepted && cfg_issued == cfg_accepted) begin
            next_s = 1'b0;
            next_cfg = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (draining) begin
                if (expected_events.size() == 0) begin
                    if (settle_left > 0) settle_left--;
                    else draining = 1'b0;
                end
            end else if (pending_stimulus.size() > 0) begin
                if (pending_stimulus.size() >= TAIL_ITEMS && $urandom_range(0, 3) == 0) begin
                    gap_left = $urandom_range(0, 6);
                end else begin
                    st = pending_stimulus.pop_front();
                    case (st.op)
                        STIM_RECORD: begin
                            s_kind <= st.rec.kind;
                            s_action <= st.rec.action;
                            s_action_pointer <= st.rec.aptr;
                            s_pointer_index <= st.rec.ptr;
                            s_pos_x <= st.rec.x;
                            s_pos_y <= st.rec.y;
                            s_last_pointer <= st.rec.last;
                            next_s = 1'b1;
                            rec_issued++;
                        end
                        STIM_REG_WRITE: begin
                            cfg_index <= st.reg_index;
                            cfg_data <= st.reg_value;
                            next_cfg = 1'b1;
                            cfg_issued++;
                        end
                        default: begin
                            draining = 1'b1;
                            settle_left = SETTLE_CYCLES;
                        end
                    endcase
                end
            end
        end
        s_valid <= next_s;
        cfg_valid <= next_cfg;
        quiet_tail <= (pending_stimulus.size() < TAIL_ITEMS);
    end

    // ------------------------------------------------------------------
    // receiver: result back-pressure
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : receiver
        logic next_ready;
        next_ready = 1'b1;
        if (long_hold_left > 0) begin
            long_hold_left--;
            next_ready = 1'b0;
        end else if (!long_hold_done && rec_accepted >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            long_hold_left = LONG_HOLD_CYCLES;
            next_ready = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            next_ready = 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 6);
            next_ready = 1'b0;
        end
        m_ready <= next_ready;
    end

    // ------------------------------------------------------------------
    // monitor: sampled on the rising edge
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        touch_event_t want;
        touch_rec_t   rec;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_events.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual kind %0d slot %0d",
                             $time, m_event_kind, m_slot);
                    mismatches++;
                end else begin
                    want = expected_events.pop_front();
                    check_field("event_kind", want.ev_kind, m_event_kind);
                    check_field("slot", want.slot, m_slot);
                    check_field("old_x", want.old_x, m_old_x);
                    check_field("old_y", want.old_y, m_old_y);
                    check_field("new_x", want.new_x, m_new_x);
                    check_field("new_y", want.new_y, m_new_y);
                    check_field("last_result", want.last, m_last_result);
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_INVERSE_SCALE) inv_scale_reg = cfg_data;
                else if (cfg_index == REG_MOVE_THRESHOLD) motion_thresh_reg = cfg_data;
                cfg_accepted++;
            end
            if (s_valid && s_ready) begin
                rec.kind = s_kind;
                rec.action = s_action;
                rec.aptr = s_action_pointer;
                rec.ptr = s_pointer_index;
                rec.x = s_pos_x;
                rec.y = s_pos_y;
                rec.last = s_last_pointer;
                track_pointer_record(rec);
                rec_accepted++;
            end
        end
    end

    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("touch_slot_tracker_test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin : sequencer
        int unsigned target;
        logic [CFG_DATA_W-1:0] inv, thr;

        // default registers
        push_record(KIND_POINTER, ACT_DOWN, 4'd0, 4'd0, 16'h0000, 16'h0000, 1'b1);
        push_record(KIND_POINTER, ACT_MOVE, 4'd0, 4'd0, 16'hFFFF, 16'hFFFF, 1'b1);
        push_record(KIND_POINTER, ACT_PTR_DOWN, 4'd1, 4'd0, 16'hFFFF, 16'hFFFF, 1'b0);
        push_record(KIND_POINTER, ACT_PTR_DOWN, 4'd1, 4'd1, 16'h1234, 16'hABCD, 1'b1);
        // slot reset ignores every other field
        push_record(KIND_RESET, ACT_RESERVED, 4'hF, 4'hF, 16'hFFFF, 16'hFFFF, 1'b1);
        push_record(KIND_POINTER, ACT_MOVE, 4'd0, 4'd0, 16'h0010, 16'h0010, 1'b1);
        push_record(KIND_POINTER, ACT_PTR_UP, 4'd0, 4'd0, 16'h0020, 16'h0020, 1'b0);
        push_record(KIND_POINTER, ACT_PTR_UP, 4'd0, 4'd1, 16'h5555, 16'hAAAA, 1'b1);
        push_record(KIND_POINTER, ACT_UP, 4'd0, 4'd0, 16'h5555, 16'hAAAA, 1'b1);
        // pointers without a slot
        push_record(KIND_POINTER, ACT_MOVE, 4'd9, 4'd9, 16'h0F0F, 16'hF0F0, 1'b1);
        push_record(KIND_POINTER, ACT_UP, 4'd15, 4'd15, 16'h8000, 16'h0001, 1'b1);
        push_record(KIND_POINTER, ACT_RESERVED, 4'd0, 4'd0, 16'h1111, 16'h2222, 1'b1);
        push_record(KIND_POINTER, ACT_OTHER, 4'd0, 4'd0, 16'h3333, 16'h4444, 1'b1);
        // fill the table, the sixth pointer finds no slot
        for (int i = 0; i < 6; i++) begin
            push_record(KIND_POINTER, ACT_PTR_DOWN, 4'd5, PTR_W'(i),
                        POS_W'($urandom), POS_W'($urandom), i == 5);
        end
        push_settle();
        push_reg_write(REG_INVERSE_SCALE, 16'd0);
        push_reg_write(REG_MOVE_THRESHOLD, 16'hFFFF);
        push_reg_write(REG_UNUSED_LO, 16'hFFFF);
        push_reg_write(REG_UNUSED_HI, 16'h0000);
        push_record(KIND_POINTER, ACT_MOVE, 4'd0, 4'd0, 16'hABCD, 16'h5555, 1'b1);
        push_record(KIND_RESET, ACT_DOWN, 4'd0, 4'd0, 16'h0000, 16'h0000, 1'b0);
        push_record(KIND_RESET, ACT_DOWN, 4'd0, 4'd0, 16'h0000, 16'h0000, 1'b0);
        push_settle();
        push_reg_write(REG_INVERSE_SCALE, 16'hFFFF);
        push_reg_write(REG_MOVE_THRESHOLD, 16'd0);
        push_record(KIND_POINTER, ACT_PTR_DOWN, 4'd3, 4'd3, 16'h8000, 16'h0001, 1'b1);
        push_record(KIND_POINTER, ACT_UP, 4'd2, 4'd2, 16'h7FFF, 16'hFFFE, 1'b1);

        target = records_queued;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin inv = INVERSE_SCALE_RST; thr = 16'd0; end
                1: begin inv = 16'($urandom_range(2048, 12288)); thr = 16'($urandom_range(0, 400)); end
                2: begin inv = 16'($urandom_range(1, 65535)); thr = 16'($urandom); end
                default: begin inv = 16'd1 + 16'($urandom_range(0, 1)) * 16'hFFFE; thr = 16'd64; end
            endcase
            push_settle();
            push_reg_write(REG_INVERSE_SCALE, inv);
            push_reg_write(REG_MOVE_THRESHOLD, thr);
            if (p == 2) push_reg_write(CFG_IDX_W'($urandom_range(2, 255)), 16'($urandom));
            target += RANDOM_RECORDS / RANDOM_PHASES;
            while (records_queued < target) add_gesture();
        end

        @(negedge aclk);
        while (pending_stimulus.size() != 0 || draining || gap_left != 0 ||
               rec_issued != rec_accepted || cfg_issued != cfg_accepted ||
               expected_events.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatches == 0) begin
            $display("touch_slot_tracker_test passed");
        end else begin
            $display("touch_slot_tracker_test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/tst_pkg.sv
hdl/tst_ctrl.sv
hdl/tst_datapath.sv
hdl/touch_slot_tracker.sv
verif/touch_slot_tracker_test.sv
